// ===== rtl/ufre_pkg.sv =====
// Shared types, constants and register indexes for the UART frame receive/echo core.
package ufre_pkg;

    localparam int MAX_FRAME = 32;
    localparam int FILL_W    = $clog2(MAX_FRAME + 1);
    localparam int ADDR_W    = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;

    localparam int PERIOD_W  = 16;
    localparam int LENGTH_W  = 6;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_BIT_PERIOD   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LENGTH = 1'b1;

    localparam logic [PERIOD_W-1:0] BIT_PERIOD_RESET   = 16'd5000;
    localparam logic [LENGTH_W-1:0] FRAME_LENGTH_RESET = 6'd19;
    localparam logic [PERIOD_W-1:0] MIN_PERIOD         = 16'd4;

    // Bit phase codes: 0 is the start bit, 1..8 the data bits, 9 idle or stop.
    localparam logic [3:0] PHASE_START = 4'd0;
    localparam logic [3:0] PHASE_FIRST = 4'd1;
    localparam logic [3:0] PHASE_STOP  = 4'd9;

    typedef struct packed {
        logic             echo_busy;
        logic [5:0]       bytes_held;
        logic [7:0]       byte_value;
        logic             byte_valid;
        logic             tx_level;
    } result_t;

endpackage

// ===== rtl/ufre_line_engine.sv =====
// Front part: receive line decoder, frame store and echo transmitter, one step per request.
module ufre_line_engine (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              step_en,
    input  logic                              rx_level,
    input  logic                              cfg_we,
    input  logic [ufre_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ufre_pkg::PERIOD_W-1:0]     cfg_wdata,
    output ufre_pkg::result_t                 result
);

    localparam int FW = ufre_pkg::FILL_W;
    localparam int AW = ufre_pkg::ADDR_W;
    localparam int PW = ufre_pkg::PERIOD_W;
    localparam int LW = ufre_pkg::LENGTH_W;

    logic [PW-1:0] bit_period_reg;
    logic [LW-1:0] frame_length_reg;

    logic [3:0]    rx_phase_reg, rx_phase_next;
    logic [PW-1:0] rx_timer_reg, rx_timer_next;
    logic [7:0]    rx_shift_reg, rx_shift_next;
    logic          prev_rx_reg;
    logic [FW-1:0] fill_reg, fill_next;
    logic [FW-1:0] tx_idx_reg, tx_idx_next;
    logic [3:0]    tx_phase_reg, tx_phase_next;
    logic [PW-1:0] tx_timer_reg, tx_timer_next;
    logic          tx_active_reg, tx_active_next;

    logic [7:0]    store_mem [ufre_pkg::MAX_FRAME];
    logic [7:0]    rd_data_reg;
    logic          store_we;

    logic [PW-1:0] per;
    logic [PW-1:0] per_m1;
    logic [PW-1:0] half_m1;
    logic [FW-1:0] eff_len;
    logic [FW-1:0] idx_inc;
    logic [2:0]    rx_bit;
    logic [2:0]    tx_bit;
    logic          byte_valid;
    logic [7:0]    byte_value;
    logic          tx_level;

    assign per     = (bit_period_reg < ufre_pkg::MIN_PERIOD) ? ufre_pkg::MIN_PERIOD
                                                             : bit_period_reg;
    assign per_m1  = per - PW'(1);
    assign half_m1 = (per >> 1) - PW'(1);
    assign idx_inc = tx_idx_reg + FW'(1);
    assign rx_bit  = rx_phase_reg[2:0] - 3'd1;

    always_comb begin
        if (frame_length_reg == '0) begin
            eff_len = FW'(1);
        end else if (FW'(frame_length_reg) > FW'(ufre_pkg::MAX_FRAME)) begin
            eff_len = FW'(ufre_pkg::MAX_FRAME);
        end else begin
            eff_len = FW'(frame_length_reg);
        end
    end

    always_comb begin
        rx_phase_next  = rx_phase_reg;
        rx_timer_next  = rx_timer_reg;
        rx_shift_next  = rx_shift_reg;
        fill_next      = fill_reg;
        tx_idx_next    = tx_idx_reg;
        tx_phase_next  = tx_phase_reg;
        tx_timer_next  = tx_timer_reg;
        tx_active_next = tx_active_reg;
        store_we       = 1'b0;
        byte_valid     = 1'b0;
        byte_value     = 8'd0;

        if (tx_active_reg) begin
            if (tx_timer_reg != '0) begin
                tx_timer_next = tx_timer_reg - PW'(1);
            end else begin
                tx_timer_next = per_m1;
                if (tx_phase_reg < ufre_pkg::PHASE_STOP) begin
                    tx_phase_next = tx_phase_reg + 4'd1;
                end else begin
                    tx_phase_next = ufre_pkg::PHASE_START;
                    tx_idx_next   = idx_inc;
                    if (idx_inc >= fill_reg) begin
                        tx_active_next = 1'b0;
                        tx_idx_next    = '0;
                        fill_next      = '0;
                    end
                end
            end
        end else if (rx_phase_reg >= ufre_pkg::PHASE_STOP) begin
            if (prev_rx_reg && !rx_level) begin
                rx_phase_next = ufre_pkg::PHASE_START;
                rx_timer_next = half_m1;
            end
        end else if (rx_timer_reg != '0) begin
            rx_timer_next = rx_timer_reg - PW'(1);
        end else begin
            rx_timer_next = per_m1;
            if (rx_phase_reg == ufre_pkg::PHASE_START) begin
                rx_phase_next = ufre_pkg::PHASE_FIRST;
            end else begin
                rx_shift_next[rx_bit] = rx_level;
                rx_phase_next = rx_phase_reg + 4'd1;
                if (rx_phase_next >= ufre_pkg::PHASE_STOP) begin
                    rx_phase_next = ufre_pkg::PHASE_STOP;
                    rx_timer_next = '0;
                    byte_valid    = 1'b1;
                    byte_value    = rx_shift_next;
                    if (fill_reg < FW'(ufre_pkg::MAX_FRAME)) begin
                        store_we  = 1'b1;
                        fill_next = fill_reg + FW'(1);
                    end
                    if (fill_next >= eff_len) begin
                        tx_active_next = 1'b1;
                        tx_idx_next    = '0;
                        tx_phase_next  = ufre_pkg::PHASE_START;
                        tx_timer_next  = per_m1;
                    end
                end
            end
        end
    end

    // The byte under transmission is addressed no later than the start of its start bit, a full
    // bit period before its first data bit, so the registered store read is always settled when it is used.
    assign tx_bit = tx_phase_next[2:0] - 3'd1;

    always_comb begin
        if (!tx_active_next) begin
            tx_level = 1'b1;
        end else if (tx_phase_next == ufre_pkg::PHASE_START) begin
            tx_level = 1'b0;
        end else if (tx_phase_next >= ufre_pkg::PHASE_STOP) begin
            tx_level = 1'b1;
        end else begin
            tx_level = rd_data_reg[tx_bit];
        end
    end

    always_comb begin
        result.tx_level   = tx_level;
        result.byte_valid = byte_valid;
        result.byte_value = byte_value;
        result.bytes_held = 6'(fill_next);
        result.echo_busy  = tx_active_next;
    end

    always_ff @(posedge aclk) begin
        if (step_en && store_we) begin
            store_mem[fill_reg[AW-1:0]] <= rx_shift_next;
        end
        rd_data_reg <= store_mem[tx_idx_reg[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_period_reg   <= ufre_pkg::BIT_PERIOD_RESET;
            frame_length_reg <= ufre_pkg::FRAME_LENGTH_RESET;
        end else if (cfg_we) begin
            if (cfg_index == ufre_pkg::CFG_BIT_PERIOD) begin
                bit_period_reg <= cfg_wdata;
            end else if (cfg_index == ufre_pkg::CFG_FRAME_LENGTH) begin
                frame_length_reg <= cfg_wdata[LW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rx_phase_reg  <= ufre_pkg::PHASE_STOP;
            rx_timer_reg  <= '0;
            rx_shift_reg  <= '0;
            prev_rx_reg   <= 1'b1;
            fill_reg      <= '0;
            tx_idx_reg    <= '0;
            tx_phase_reg  <= ufre_pkg::PHASE_START;
            tx_timer_reg  <= '0;
            tx_active_reg <= 1'b0;
        end else if (step_en) begin
            rx_phase_reg  <= rx_phase_next;
            rx_timer_reg  <= rx_timer_next;
            rx_shift_reg  <= rx_shift_next;
            prev_rx_reg   <= rx_level;
            fill_reg      <= fill_next;
            tx_idx_reg    <= tx_idx_next;
            tx_phase_reg  <= tx_phase_next;
            tx_timer_reg  <= tx_timer_next;
            tx_active_reg <= tx_active_next;
        end
    end

endmodule

// ===== rtl/ufre_result_queue.sv =====
// Back part: two-entry result queue that drives the output stream.
module ufre_result_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  ufre_pkg::result_t push_data,
    output logic              has_room,
    output logic              out_valid,
    input  logic              out_ready,
    output ufre_pkg::result_t out_data
);

    ufre_pkg::result_t slot_reg [2];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [1:0]        count_reg, count_next;
    logic              pop;

    assign has_room  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/uart_frame_receive_echo_core.sv =====
// Top level of the 8N1 UART frame receiver with frame echo.
// Each input request is one sample of the receive line; each sample yields exactly one
// result request carrying the transmit line level, a received-byte strobe and value, the
// frame store fill and the echo busy flag. The core takes one sample per clock, one step
// of the line engine per request, and keeps accepting while fewer than two results wait
// in the output queue; s_axis_tready drops when that queue is full and while reset is
// held. The frame store is a 32-byte memory with one write and one registered read port.
// Configuration writes (index 0 bit period, index 1 frame length) should be made while
// the core is idle.
module uart_frame_receive_echo_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,  // [0] rx_level
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [15:0]                       m_axis_tdata,  // [0] tx_level, [8:1] byte_value,
                                                             // [14:9] bytes_held, [15] echo_busy
    output logic [0:0]                        m_axis_tuser,  // [0] byte_valid
    input  logic                              cfg_we,
    input  logic [ufre_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ufre_pkg::PERIOD_W-1:0]     cfg_wdata
);

    ufre_pkg::result_t step_result;
    ufre_pkg::result_t head;
    logic              room;
    logic              step_en;

    assign s_axis_tready = room && aresetn;
    assign step_en       = s_axis_tvalid && s_axis_tready;

    ufre_line_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (step_en),
        .rx_level  (s_axis_tdata[0]),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .result    (step_result)
    );

    ufre_result_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (step_en),
        .push_data (step_result),
        .has_room  (room),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (head)
    );

    assign m_axis_tdata = {head.echo_busy, head.bytes_held, head.byte_value, head.tx_level};
    assign m_axis_tuser = head.byte_valid;

endmodule
